[rtl/core/cto_pkg.sv]
// Shared types, codes and widths for the connection timeout table.
package cto_pkg;

    // Fixed field widths of the request and result channels
    localparam int OPCODE_W = 1;
    localparam int CONN_W   = 6;
    localparam int TIME_IN_W = 48;

    // Default configuration of the table
    localparam int DEF_MAX_CONNECTIONS = 64;
    localparam int DEF_TIME_WIDTH      = 48;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_ARM  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic arm_we;   // store deadline and set valid mark
        logic start;    // load current time and begin the scan
        logic flush;    // emit the held expiration as the final one
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_busy;   // reads still issuing or compare stage full
        logic flush_done;  // held expiration gone or nothing held
    } t_sts;

endpackage

[rtl/core/cto_if.sv]
// Request and result channel interfaces of the connection timeout table.
interface cto_req_if;
    logic                              valid;
    logic                              ready;
    logic [cto_pkg::OPCODE_W-1:0]      opcode;
    logic [cto_pkg::CONN_W-1:0]        conn_id;
    logic [cto_pkg::TIME_IN_W-1:0]     time_us;

    modport source (output valid, opcode, conn_id, time_us, input ready);
    modport sink   (input valid, opcode, conn_id, time_us, output ready);
endinterface

interface cto_exp_if;
    logic                              valid;
    logic                              ready;
    logic [cto_pkg::CONN_W-1:0]        expired_conn;
    logic                              last_expired;

    modport source (output valid, expired_conn, last_expired, input ready);
    modport sink   (input valid, expired_conn, last_expired, output ready);
endinterface

[rtl/core/connection_timeout_table_core.sv]
// Top level of the connection timeout table: controller plus datapath.
//
// Requests arrive on i_req (valid/ready). An arm request (opcode OP_ARM)
// stores the deadline time_us for slot conn_id and marks it valid; ids at
// or beyond MAX_CONNECTIONS are dropped. After an arm, the next request
// can be taken in the following cycle. A tick request (OP_TICK)
// carries the current time; the block reads the deadline memory one slot
// per cycle and emits on o_exp the index of every valid slot whose
// deadline is strictly below that time, clearing its mark. Results leave
// in ascending slot order and the final one of a tick has last_expired
// set. A tick holds i_req.ready low while the scan reads the deadline
// memory through its single read port and flushes the held result;
// whenever a result cannot move because o_exp is stalled, the scan
// halts and waits. One finished result can sit in the output register
// while the next request is taken. Reset clears all valid marks at once;
// deadline contents need no clearing: an entry counts only while marked.
module connection_timeout_table_core #(
    parameter int MAX_CONNECTIONS = cto_pkg::DEF_MAX_CONNECTIONS,
    parameter int TIME_WIDTH      = cto_pkg::DEF_TIME_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cto_req_if.sink   i_req,
    cto_exp_if.source o_exp
);

    cto_pkg::t_cmd cmd;
    cto_pkg::t_sts sts;

    // Sequence requests and the scan
    cto_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_opcode    (i_req.opcode),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // Store deadlines, scan and deliver expirations
    cto_dp #(
        .MAX_CONNECTIONS (MAX_CONNECTIONS),
        .TIME_WIDTH      (TIME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_conn_id      (i_req.conn_id),
        .i_time_us      (i_req.time_us),
        .i_out_ready    (o_exp.ready),
        .o_sts          (sts),
        .o_out_valid    (o_exp.valid),
        .o_expired_conn (o_exp.expired_conn),
        .o_last_expired (o_exp.last_expired)
    );

endmodule

[rtl/core/cto_ctrl.sv]
// Controller state machine: request acceptance, scan and final flush.
module cto_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic [cto_pkg::OPCODE_W-1:0]  i_opcode,
    input  cto_pkg::t_sts                 i_sts,
    output logic                          o_req_ready,
    output cto_pkg::t_cmd                 o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       req_acc;

    // Take requests only between scans
    assign o_req_ready = (r_state == ST_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;

    // Issue datapath commands
    always_comb begin
        o_cmd.arm_we = req_acc && (i_opcode == cto_pkg::OP_ARM);
        o_cmd.start  = req_acc && (i_opcode == cto_pkg::OP_TICK);
        o_cmd.flush  = (r_state == ST_FLUSH);
    end

    // Advance the state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_sts.flush_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/cto_dp.sv]
// Datapath: deadline memory, valid marks, scan pipeline and result register.
module cto_dp #(
    parameter int MAX_CONNECTIONS = cto_pkg::DEF_MAX_CONNECTIONS,
    parameter int TIME_WIDTH      = cto_pkg::DEF_TIME_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cto_pkg::t_cmd                  i_cmd,
    input  logic [cto_pkg::CONN_W-1:0]     i_conn_id,
    input  logic [cto_pkg::TIME_IN_W-1:0]  i_time_us,
    input  logic                           i_out_ready,
    output cto_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    output logic [cto_pkg::CONN_W-1:0]     o_expired_conn,
    output logic                           o_last_expired
);

    localparam int IDX_W = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int CMP_W = (IDX_W + 1 > cto_pkg::CONN_W) ? IDX_W + 1 : cto_pkg::CONN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CONNECTIONS - 1);

    logic [TIME_WIDTH-1:0] r_mem [MAX_CONNECTIONS];
    logic [MAX_CONNECTIONS-1:0] r_valid;

    logic [TIME_WIDTH-1:0] r_time;
    logic [IDX_W-1:0]      r_scan_idx;
    logic                  r_issue;
    logic [TIME_WIDTH-1:0] r_rd_data;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_pend_idx;
    logic                  r_pend_vld;
    logic                  r_out_vld;
    logic [cto_pkg::CONN_W-1:0] r_out_conn;
    logic                  r_out_last;

    logic [IDX_W-1:0]      arm_idx;
    logic                  arm_ok;
    logic                  out_space;
    logic                  hit;
    logic                  stall;
    logic                  push_mid;
    logic                  push_last;

    // Decode the arm target; ids beyond the table are dropped
    assign arm_idx = IDX_W'(i_conn_id);
    assign arm_ok  = CMP_W'(i_conn_id) < CMP_W'(MAX_CONNECTIONS);

    // Compare stage and result hand-off
    assign out_space = !r_out_vld || i_out_ready;
    assign hit       = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data < r_time);
    assign stall     = hit && r_pend_vld && !out_space;
    assign push_mid  = hit && r_pend_vld && out_space;
    assign push_last = i_cmd.flush && r_pend_vld && out_space;

    assign o_sts.scan_busy  = r_issue || r_cmp_vld;
    assign o_sts.flush_done = !r_pend_vld || out_space;

    assign o_out_valid    = r_out_vld;
    assign o_expired_conn = r_out_conn;
    assign o_last_expired = r_out_last;

    // Write deadlines, read one entry per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.arm_we && arm_ok) begin
            r_mem[arm_idx] <= TIME_WIDTH'(i_time_us);
        end
        if (!stall) begin
            r_rd_data <= r_mem[r_scan_idx];
            r_cmp_idx <= r_scan_idx;
        end
    end

    // Hold the tick time
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_time <= TIME_WIDTH'(i_time_us);
        end
    end

    // Set valid marks on arm, drop them on expiration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.arm_we && arm_ok) begin
            r_valid[arm_idx] <= 1'b1;
        end else if (hit && !stall) begin
            r_valid[r_cmp_idx] <= 1'b0;
        end
    end

    // Step the scan address and compare-stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_issue    <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else if (i_cmd.start) begin
            r_scan_idx <= '0;
            r_issue    <= 1'b1;
        end else if (!stall) begin
            r_cmp_vld <= r_issue;
            if (r_issue) begin
                if (r_scan_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
        end
    end

    // Hold the latest expiration until the next one or the scan end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (hit && !stall) begin
            r_pend_vld <= 1'b1;
        end else if (push_last) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit && !stall) begin
            r_pend_idx <= r_cmp_idx;
        end
    end

    // Load the result register or drain it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push_mid || push_last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid || push_last) begin
            r_out_conn <= cto_pkg::CONN_W'(r_pend_idx);
            r_out_last <= push_last;
        end
    end

endmodule

[bench/connection_timeout_table_core_tb.sv]
// Self-checking bench for the connection timeout table: directed, stall and random traffic.
module connection_timeout_table_core_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int NUM_SLOTS    = cto_pkg::DEF_MAX_CONNECTIONS;
    localparam int TICK_LATENCY = NUM_SLOTS + 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam logic [cto_pkg::TIME_IN_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [cto_pkg::CONN_W-1:0] conn;
        logic                       last;
    } t_expiry;

    logic i_clk;
    logic i_rst_n;

    cto_req_if req_if ();
    cto_exp_if exp_if ();

    connection_timeout_table_core #(
        .MAX_CONNECTIONS (cto_pkg::DEF_MAX_CONNECTIONS),
        .TIME_WIDTH      (cto_pkg::DEF_TIME_WIDTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_exp   (exp_if)
    );

    // Shadow copy of the table and the expirations still due
    logic [cto_pkg::TIME_IN_W-1:0] deadline_tbl [NUM_SLOTS];
    bit                            armed        [NUM_SLOTS];
    t_expiry                       expiry_q     [$];

    int  err_count    = 0;
    int  report_count = 0;
    int  n_arms       = 0;
    int  n_ticks      = 0;
    int  n_expired    = 0;
    bit  src_gaps_on  = 1'b1;
    bit  sink_gaps_on = 1'b1;
    bit  hold_req     = 1'b0;

    // Toggle the clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Pick an idle length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [cto_pkg::TIME_IN_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[cto_pkg::TIME_IN_W-1:0];
    endfunction

    // Update the shadow table and queue the expirations a request causes
    task automatic predict_request(input logic [cto_pkg::OPCODE_W-1:0] op,
                                   input logic [cto_pkg::CONN_W-1:0] id,
                                   input logic [cto_pkg::TIME_IN_W-1:0] t);
        t_expiry e;
        int      found;
        found = 0;
        if (op == cto_pkg::OP_ARM) begin
            deadline_tbl[id] = t;
            armed[id]        = 1'b1;
            n_arms++;
        end else begin
            n_ticks++;
            for (int slot = 0; slot < NUM_SLOTS; slot++) begin
                if (armed[slot] && deadline_tbl[slot] < t) begin
                    armed[slot] = 1'b0;
                    e.conn      = slot[cto_pkg::CONN_W-1:0];
                    e.last      = 1'b0;
                    expiry_q.push_back(e);
                    found++;
                end
            end
            if (found > 0) begin
                e      = expiry_q[expiry_q.size() - 1];
                e.last = 1'b1;
                expiry_q[expiry_q.size() - 1] = e;
            end
        end
    endtask

    // Offer one request and hold it until the block takes it
    task automatic issue_request(input logic [cto_pkg::OPCODE_W-1:0] op,
                                 input logic [cto_pkg::CONN_W-1:0] id,
                                 input logic [cto_pkg::TIME_IN_W-1:0] t);
        req_if.valid   <= 1'b1;
        req_if.opcode  <= op;
        req_if.conn_id <= id;
        req_if.time_us <= t;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        predict_request(op, id, t);
    endtask

    // Drop valid for a random gap, if gaps are enabled
    task automatic sender_pause();
        int n;
        n = 0;
        if (src_gaps_on && $urandom_range(0, 2) == 0)
            n = gap_len();
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic arm(input logic [cto_pkg::CONN_W-1:0] id,
                       input logic [cto_pkg::TIME_IN_W-1:0] t);
        issue_request(cto_pkg::OP_ARM, id, t);
        sender_pause();
    endtask

    task automatic tick(input logic [cto_pkg::TIME_IN_W-1:0] t);
        issue_request(cto_pkg::OP_TICK,
                      cto_pkg::CONN_W'($urandom_range(0, NUM_SLOTS - 1)), t);
        sender_pause();
    endtask

    // Drive result ready: random stalls, or a long hold when asked
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                exp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!sink_gaps_on) begin
                exp_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                exp_if.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = gap_len() - 1;
                exp_if.ready <= 1'b0;
            end else begin
                exp_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted expiration with the oldest one due
    always @(posedge i_clk) begin
        t_expiry want;
        if (i_rst_n && exp_if.valid && exp_if.ready) begin
            if (expiry_q.size() == 0) begin
                err_count++;
                if (report_count < 10)
                    $display("ERROR: unexpected expiration conn=%0d last=%0b",
                             exp_if.expired_conn, exp_if.last_expired);
                report_count++;
            end else begin
                want = expiry_q.pop_front();
                n_expired++;
                if (exp_if.expired_conn !== want.conn ||
                    exp_if.last_expired !== want.last) begin
                    err_count++;
                    if (report_count < 10)
                        $display("ERROR: expected conn=%0d last=%0b, got conn=%0d last=%0b",
                                 want.conn, want.last,
                                 exp_if.expired_conn, exp_if.last_expired);
                    report_count++;
                end
            end
        end
    end

    // Ticks on an empty table expire nothing
    task automatic test_empty_table();
        tick(48'd5);
        tick(TIME_MAX);
    endtask

    // Extremes of slot and time, strict comparison, refresh of a valid slot
    task automatic test_boundaries();
        arm(6'd0, '0);
        arm(6'd63, TIME_MAX);
        arm(6'd5, 48'd100);
        tick(48'd100);
        tick(48'd101);
        tick(TIME_MAX);
        arm(6'd63, 48'd10);
        tick(48'd11);
        tick('0);
    endtask

    // Refresh before expiry, and several expirations in index order
    task automatic test_refresh_and_order();
        arm(6'd7, 48'd50);
        arm(6'd7, 48'd200);
        tick(48'd60);
        tick(48'd200);
        tick(48'd201);
        arm(6'd40, 48'd1000);
        arm(6'd12, 48'd5);
        arm(6'd33, 48'd999);
        tick(48'd1001);
    endtask

    // Expire every slot in one tick while the receiver holds off
    task automatic test_full_table_stall();
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++)
            arm(cto_pkg::CONN_W'(s), 48'($urandom_range(0, 100000)));
        tick(48'd100001);
        arm(6'd3, 48'd5);
        arm(6'd62, 48'd7);
        tick(48'd10);
        arm(6'd9, 48'd20);
        tick(48'd30);
        src_gaps_on = 1'b1;
    endtask

    // Mostly ordered arms and advancing ticks, with some random-time noise
    task automatic test_random_traffic();
        logic [cto_pkg::TIME_IN_W-1:0] now;
        logic [cto_pkg::CONN_W-1:0]    id;
        int                            kind;
        now = 48'd1000;
        for (int i = 0; i < 80; i++) begin
            // run a stretch with no idling on either side
            if (i == 30) begin
                src_gaps_on  = 1'b0;
                sink_gaps_on = 1'b0;
            end else if (i == 55) begin
                src_gaps_on  = 1'b1;
                sink_gaps_on = 1'b1;
            end
            // move to a new time base now and then, including both ends
            if (i % 40 == 39) begin
                case ($urandom_range(0, 2))
                    0:       now = 48'($urandom_range(0, 50));
                    1:       now = TIME_MAX - 48'($urandom_range(0, 2000));
                    default: now = rand_time();
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                id = cto_pkg::CONN_W'($urandom_range(0, 7));
            else
                id = cto_pkg::CONN_W'($urandom_range(0, NUM_SLOTS - 1));
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
                arm(id, now + 48'($urandom_range(0, 300)));
            end else if (kind < 17) begin
                now = now + 48'($urandom_range(0, 120));
                tick(now);
            end else if (kind == 17) begin
                arm(id, rand_time());
            end else begin
                tick(rand_time());
            end
        end
    endtask

    // Run the tests in turn, then drain and report
    initial begin
        int spin;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.opcode  <= cto_pkg::OP_ARM;
        req_if.conn_id <= '0;
        req_if.time_us <= '0;
        exp_if.ready   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_boundaries();
        test_refresh_and_order();
        test_full_table_stall();
        test_random_traffic();
        req_if.valid <= 1'b0;

        // wait for the expirations still due, then for a stray late one
        spin = 0;
        while (expiry_q.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (TICK_LATENCY + 8) @(posedge i_clk);
        if (expiry_q.size() != 0) begin
            err_count += expiry_q.size();
            $display("ERROR: %0d expirations never arrived", expiry_q.size());
        end

        $display("Sent %0d arms and %0d ticks; checked %0d expirations in slot order,",
                 n_arms, n_ticks, n_expired);
        $display("including a full-table tick under a %0d-cycle receiver hold.", HOLD_CYCLES);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("Errors: %0d", err_count);
            $display("FAILURE");
        end
        $finish;
    end

    // End a run that hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
rtl/core/cto_pkg.sv
rtl/core/cto_if.sv
rtl/core/cto_ctrl.sv
rtl/core/cto_dp.sv
rtl/core/connection_timeout_table_core.sv
bench/connection_timeout_table_core_tb.sv
